// ===== sv/udp_ipv4_header_generator_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the UDP/IPv4 header generator checker
// Each macro places one labelled concurrent assertion on the block clock,
// switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef UDP_IPV4_HEADER_GENERATOR_UNIT_ASSERT_SVH
`define UDP_IPV4_HEADER_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define UHG_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define UHG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/uhg_pkg.sv =====
// ---------------------------------------------------------------------------
// UDP/IPv4 header generator package
// Shared widths, header constants, job and status types, and the ones'
// complement carry fold.
// ---------------------------------------------------------------------------
`default_nettype none

package uhg_pkg;

   // Payload byte count never exceeds 65507, so 16 bits hold it
   localparam int CountW      = 16;
   localparam int MaxPayload  = 65507;
   localparam int QueueDepth  = 2;

   localparam int HdrLen      = 42;
   localparam int HdrIdxW     = 6;
   localparam int CsrIdxW     = 3;
   localparam int CsrDataW    = 48;

   // Fixed header words
   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [15:0] IpVerIhlTos   = 16'h4500;
   localparam logic [15:0] IpIdent       = 16'h0000;
   localparam logic [15:0] IpFlagsDf     = 16'h4000;
   localparam logic [15:0] IpTtlProto    = 16'h4011;
   localparam logic [15:0] UdpProto      = 16'h0011;
   localparam logic [15:0] IpLenBase     = 16'd28;
   localparam logic [15:0] UdpLenBase    = 16'd8;
   localparam logic [15:0] AllOnes16     = 16'hFFFF;
   // Sum of the fixed IPv4 header words
   localparam logic [19:0] IpFixedSum    = 20'h0C511;

   // Configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_DEST_MAC    = 3'd0,
      CSR_SOURCE_MAC  = 3'd1,
      CSR_SOURCE_IP   = 3'd2,
      CSR_DEST_IP     = 3'd3,
      CSR_SOURCE_PORT = 3'd4,
      CSR_DEST_PORT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } cfg_type;

   // One finished packet, handed from front to back
   typedef struct packed {
      logic              err;
      logic [CountW-1:0] count;
      logic [15:0]       sum;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WORDS,
      BK_SUMS,
      BK_FOLD,
      BK_EMIT
   } back_state_type;

   // Fold a sum of up to 20 bits into 16 bits, end-around carry fully applied
   function automatic logic [15:0] fold20(input logic [19:0] x);
      logic [16:0] t;
      t = {1'b0, x[15:0]} + {13'b0, x[19:16]};
      return t[15:0] + {15'b0, t[16]};
   endfunction

endpackage

`default_nettype wire

// ===== sv/udp_ipv4_header_generator_unit.sv =====
// ---------------------------------------------------------------------------
// UDP/IPv4 header generator
// Sums UDP payload bytes and emits the Ethernet/IPv4/UDP header per packet.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one payload request a cycle (a byte, an empty slot, or the
//   end mark). One request is taken every cycle; req_stall rises only while
//   QUEUE_DEPTH finished packets wait for the header emitter.
//   rsp_* streams 42 header bytes in wire order, the last one flagged, or a
//   single too_long result when the payload passed MAX_PAYLOAD.
//   csr_* writes the MAC, IP and port registers (index 0 to 5, others
//   ignored); csr_ready is always high. Write only while the block is idle.
// Timing:
//   The first header byte follows the end request once the emitter is
//   free, after pick-up, word sums, totals and carry fold. Bytes then
//   follow one a cycle while rsp_stall is low; the emitter takes the next
//   job only after the last byte of a header. A too_long result passes
//   through pick-up and emit only.
//   rsp_stall holds the byte in the output register and pauses the stream.
// Reset: synchronous, clears config, packet, queue, emitter state at once.
// ---------------------------------------------------------------------------
`default_nettype none

module udp_ipv4_header_generator_unit
   import uhg_pkg::*;
#(
   parameter int MAX_PAYLOAD = MaxPayload,
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_has_byte,
   input  wire logic                req_end_of_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_header_byte,
   output logic                     rsp_last_header_byte,
   output logic                     rsp_too_long,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   q_stat_type q_stat;
   logic       push;
   job_type    push_job;
   logic       pop;
   job_type    head;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEST_MAC:    cfg_in.dest_mac    = csr_data[47:0];
            CSR_SOURCE_MAC:  cfg_in.source_mac  = csr_data[47:0];
            CSR_SOURCE_IP:   cfg_in.source_ip   = csr_data[31:0];
            CSR_DEST_IP:     cfg_in.dest_ip     = csr_data[31:0];
            CSR_SOURCE_PORT: cfg_in.source_port = csr_data[15:0];
            CSR_DEST_PORT:   cfg_in.dest_port   = csr_data[15:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uhg_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_payload (req_end_of_payload),
      .q_stat             (q_stat),
      .push               (push),
      .push_job           (push_job)
   );

   uhg_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   uhg_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head                 (head),
      .q_stat               (q_stat),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_header_byte      (rsp_header_byte),
      .rsp_last_header_byte (rsp_last_header_byte),
      .rsp_too_long         (rsp_too_long)
   );

endmodule

`default_nettype wire

// ===== sv/uhg_front.sv =====
// ---------------------------------------------------------------------------
// UDP/IPv4 header generator front end
// Accepts payload requests, keeps the running ones' complement sum, odd
// byte and byte count, and queues one job per finished packet.
// ---------------------------------------------------------------------------
`default_nettype none

module uhg_front
   import uhg_pkg::*;
#(
   parameter int MAX_PAYLOAD = MaxPayload
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_has_byte,
   input  wire logic       req_end_of_payload,
   input  wire q_stat_type q_stat,
   output logic            push,
   output job_type         push_job
);

   logic [15:0]       sum_ff, sum_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [7:0]        held_ff, held_in;
   logic              odd_ff, odd_in;
   logic              ovf_ff, ovf_in;

   logic              accept;
   logic              take;
   logic              ovf_hit;
   logic              pair;
   logic              odd_new;
   logic [7:0]        held_new;
   logic [15:0]       addend;
   logic [16:0]       raw_sum;
   logic [15:0]       sum_new;
   logic [CountW-1:0] count_new;

   // Stall only while the job queue is full
   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   // Classify the request: byte taken, byte overflowing, or nothing
   assign take    = accept && req_has_byte && !ovf_ff && (count_ff < CountW'(MAX_PAYLOAD));
   assign ovf_hit = accept && req_has_byte && !ovf_ff && (count_ff >= CountW'(MAX_PAYLOAD));
   assign pair    = take && odd_ff;

   assign odd_new   = take ? !odd_ff : odd_ff;
   assign held_new  = (take && !odd_ff) ? req_data_byte : held_ff;
   assign count_new = take ? count_ff + 1'b1 : count_ff;

   // One adder serves a completed word or the zero-padded odd byte at the end
   always_comb begin
      if (pair) begin
         addend = {held_ff, req_data_byte};
      end else if (req_end_of_payload && odd_new) begin
         addend = {held_new, 8'h00};
      end else begin
         addend = 16'h0000;
      end
   end

   assign raw_sum = {1'b0, sum_ff} + {1'b0, addend};
   assign sum_new = fold20({3'b000, raw_sum});

   // Queue a job on the end request
   assign push           = accept && req_end_of_payload;
   assign push_job.err   = ovf_ff || ovf_hit;
   assign push_job.count = count_new;
   assign push_job.sum   = sum_new;

   // Advance packet state, or clear it at the end of the packet
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      held_in  = held_ff;
      odd_in   = odd_ff;
      ovf_in   = ovf_ff;
      if (push) begin
         sum_in   = '0;
         count_in = '0;
         held_in  = '0;
         odd_in   = 1'b0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         sum_in   = sum_new;
         count_in = count_new;
         held_in  = pair ? 8'h00 : held_new;
         odd_in   = odd_new;
         ovf_in   = ovf_ff || ovf_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         held_ff  <= '0;
         odd_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         odd_ff   <= odd_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/uhg_queue.sv =====
// ---------------------------------------------------------------------------
// UDP/IPv4 header generator job queue
// Short first-in first-out queue of finished packet jobs between the
// front end and the header emitter.
// ---------------------------------------------------------------------------
`default_nettype none

module uhg_queue
   import uhg_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head,
   output q_stat_type   q_stat
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LvlW = $clog2(DEPTH + 1);

   job_type           slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0]   level_ff, level_in;

   assign q_stat.full  = (level_ff == LvlW'(DEPTH));
   assign q_stat.empty = (level_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/uhg_back.sv =====
// ---------------------------------------------------------------------------
// UDP/IPv4 header generator back end
// Takes one job at a time, works out lengths and both checksums in WORDS,
// SUMS and FOLD, then streams 42 header bytes or a too_long result out.
// ---------------------------------------------------------------------------
`default_nettype none

module uhg_back
   import uhg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire job_type    head,
   input  wire q_stat_type q_stat,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_header_byte,
   output logic            rsp_last_header_byte,
   output logic            rsp_too_long
);

   localparam logic [HdrIdxW-1:0] LastIdx = HdrIdxW'(HdrLen - 1);

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic [HdrIdxW-1:0] idx_ff, idx_in;
   logic [17:0]        ipw_ff, ipw_in;
   logic [16:0]        port_ff, port_in;
   logic [15:0]        ip_len_ff, ip_len_in;
   logic [15:0]        udp_len_ff, udp_len_in;
   logic [19:0]        ip_acc_ff, ip_acc_in;
   logic [19:0]        udp_acc_ff, udp_acc_in;
   logic [15:0]        ip_csum_ff, ip_csum_in;
   logic [15:0]        udp_csum_ff, udp_csum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               too_long_ff, too_long_in;

   logic                     out_free;
   logic [15:0]              udp_fold;
   logic [HdrLen-1:0][7:0]   hdr_bytes;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_header_byte      = byte_ff;
   assign rsp_last_header_byte = last_ff;
   assign rsp_too_long         = too_long_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign udp_fold = ~fold20(udp_acc_ff);

   // Header in wire order, first byte at the top
   assign hdr_bytes = {cfg.dest_mac, cfg.source_mac, EtherTypeIpv4,
                       IpVerIhlTos, ip_len_ff, IpIdent, IpFlagsDf, IpTtlProto,
                       ip_csum_ff, cfg.source_ip, cfg.dest_ip,
                       cfg.source_port, cfg.dest_port, udp_len_ff, udp_csum_ff};

   // Sequence one job: pick up, sum, fold, stream out
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      ipw_in       = ipw_ff;
      port_in      = port_ff;
      ip_len_in    = ip_len_ff;
      udp_len_in   = udp_len_ff;
      ip_acc_in    = ip_acc_ff;
      udp_acc_in   = udp_acc_ff;
      ip_csum_in   = ip_csum_ff;
      udp_csum_in  = udp_csum_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      too_long_in  = too_long_ff;
      pop          = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               job_in   = head;
               idx_in   = '0;
               state_in = head.err ? BK_EMIT : BK_WORDS;
            end
         end
         BK_WORDS: begin
            ipw_in   = {2'b00, cfg.source_ip[31:16]} + {2'b00, cfg.source_ip[15:0]}
                     + {2'b00, cfg.dest_ip[31:16]} + {2'b00, cfg.dest_ip[15:0]};
            port_in  = {1'b0, cfg.source_port} + {1'b0, cfg.dest_port};
            state_in = BK_SUMS;
         end
         BK_SUMS: begin
            ip_len_in  = IpLenBase + job_ff.count;
            udp_len_in = UdpLenBase + job_ff.count;
            ip_acc_in  = IpFixedSum + {2'b00, ipw_ff} + {4'h0, IpLenBase + job_ff.count};
            udp_acc_in = {2'b00, ipw_ff} + {4'h0, job_ff.sum} + {3'b000, port_ff}
                       + {4'h0, UdpProto}
                       + {3'b000, UdpLenBase + job_ff.count, 1'b0};
            state_in   = BK_FOLD;
         end
         BK_FOLD: begin
            ip_csum_in  = ~fold20(ip_acc_ff);
            udp_csum_in = (udp_fold == 16'h0000) ? AllOnes16 : udp_fold;
            state_in    = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (job_ff.err) begin
                  byte_in     = 8'h00;
                  last_in     = 1'b1;
                  too_long_in = 1'b1;
                  state_in    = BK_IDLE;
               end else begin
                  byte_in     = hdr_bytes[LastIdx - idx_ff];
                  last_in     = (idx_ff == LastIdx);
                  too_long_in = 1'b0;
                  idx_in      = idx_ff + 1'b1;
                  if (idx_ff == LastIdx) begin
                     state_in = BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      ipw_ff      <= ipw_in;
      port_ff     <= port_in;
      ip_len_ff   <= ip_len_in;
      udp_len_ff  <= udp_len_in;
      ip_acc_ff   <= ip_acc_in;
      udp_acc_ff  <= udp_acc_in;
      ip_csum_ff  <= ip_csum_in;
      udp_csum_ff <= udp_csum_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      too_long_ff <= too_long_in;
   end

endmodule

`default_nettype wire

// ===== sv/uhg_checker.sv =====
// ---------------------------------------------------------------------------
// UDP/IPv4 header generator port checker
// Watches the result channel of the top level and flags malformed output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "udp_ipv4_header_generator_unit_assert.svh"

module uhg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_header_byte,
   input wire logic       rsp_last_header_byte,
   input wire logic       rsp_too_long
);

   // An error result stands alone: zero byte, flagged as last
   `UHG_ASSERT_IMPL(a_err_shape, rsp_valid && rsp_too_long, rsp_last_header_byte && (rsp_header_byte == 8'h00), "too_long result must be a lone zero byte")

   // Inside a header no error result may follow
   `UHG_ASSERT_NEXT(a_hdr_cont, rsp_valid && !rsp_stall && !rsp_last_header_byte, !rsp_too_long, "error result inside a header")

   // Hold the result while stalled
   `UHG_ASSERT_NEXT(a_stall_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_header_byte) && $stable(rsp_last_header_byte) && $stable(rsp_too_long), "result changed under stall")

endmodule

bind udp_ipv4_header_generator_unit uhg_checker u_checker (.*);

`default_nettype wire
